FILE: design/stunmap_pkg.sv
// Shared types and constants for the STUN mapped address parser.
// Used by every module of the block; depends on nothing.
package stunmap_pkg;

  // Largest datagram handled; bytes beyond it are dropped.
  localparam int unsigned MAX_DATAGRAM_BYTES_DEF = 2048;

  localparam int unsigned HEADER_BYTES = 20;
  localparam logic [15:0] BINDING_RESPONSE = 16'h0101;
  localparam logic [15:0] XOR_MAPPED_ADDRESS = 16'h0020;
  localparam logic [31:0] MAGIC_COOKIE = 32'h2112_A442;
  localparam logic [7:0] FAMILY_IPV4 = 8'h01;
  localparam logic [15:0] MIN_ADDR_LEN = 16'd8;

  // Result status codes.
  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_BAD_TYPE = 2'd2;
  localparam logic [1:0] ST_NO_ADDR = 2'd3;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_ATTR_HEAD = 4'b0010,
    PH_ATTR_VALUE = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] public_address;
    logic [15:0] mapped_port;
  } out_item_t;

  // Handshake status of the input stage, handed to the top level.
  typedef struct packed {
    logic stall;
    logic go;
  } stage_ctl_t;

endpackage

FILE: design/stun_mapped_address_parser_top.sv
// Top level of the STUN XOR-MAPPED-ADDRESS parser; uses stunmap_pkg, stunmap_in_reg,
// stunmap_parse and stunmap_out_reg.
// A final byte's result passes the input register, then the result register. Input
// takes one byte per cycle, set by the single input register stage, unless stalled.
// Reset: rst_n is synchronous and active low; it empties both register stages and
// returns the parser to the header phase.
module stun_mapped_address_parser_top #(
  parameter int unsigned MAX_DATAGRAM_BYTES = stunmap_pkg::MAX_DATAGRAM_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  stunmap_pkg::in_item_t  in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output stunmap_pkg::out_item_t out_item
);

  // Each byte transfer lands in the input register, and from there it updates the
  // parse state. Only a byte with the final mark produces a result, which is then
  // written into the result register. While a result waits to be taken, ordinary
  // bytes keep flowing; only a second final byte has to wait for the result
  // register to free up, and it then holds the input stage.
  logic s1_valid;
  stunmap_pkg::in_item_t s1_item;
  stunmap_pkg::stage_ctl_t s1_ctl;
  stunmap_pkg::out_item_t result;
  logic can_load;

  stunmap_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .can_load (can_load),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .ctl      (s1_ctl)
  );

  // The parse state advances by one byte in the cycle the byte leaves the input
  // register, and the result of a final byte is formed in that same cycle.
  stunmap_parse #(
    .MAX_DATAGRAM_BYTES (MAX_DATAGRAM_BYTES)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_go (s1_ctl.go),
    .item    (s1_item),
    .result  (result)
  );

  stunmap_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_ctl.go && s1_item.last_byte),
    .result    (result),
    .out_stall (out_stall),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // The input register only ever holds up the sender when it is full and stuck.
  assign in_stall = s1_ctl.stall && s1_valid;

endmodule

FILE: design/stunmap_in_reg.sv
// Input register stage of the STUN mapped address parser.
// Depends on stunmap_pkg.
module stunmap_in_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  stunmap_pkg::in_item_t in_item,
  input  logic                  can_load,
  output logic                  s1_valid,
  output stunmap_pkg::in_item_t s1_item,
  output stunmap_pkg::stage_ctl_t ctl
);

  logic s1_valid_r, s1_valid_nxt;
  stunmap_pkg::in_item_t s1_item_r;

  // A final byte may only move on when the result register can take its result.
  always_comb begin
    ctl.go = s1_valid_r && (!s1_item_r.last_byte || can_load);
    ctl.stall = s1_valid_r && !ctl.go;
    s1_valid_nxt = s1_valid_r;
    if (in_valid && !ctl.stall) begin
      s1_valid_nxt = 1'b1;
    end else if (ctl.go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !ctl.stall) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item = s1_item_r;

endmodule

FILE: design/stunmap_parse.sv
// Parse state and per-byte update logic of the STUN mapped address parser.
// Depends on stunmap_pkg.
module stunmap_parse #(
  parameter int unsigned MAX_DATAGRAM_BYTES = stunmap_pkg::MAX_DATAGRAM_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   item_go,
  input  stunmap_pkg::in_item_t  item,
  output stunmap_pkg::out_item_t result
);

  localparam int unsigned POS_W = $clog2(MAX_DATAGRAM_BYTES + 1);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_DATAGRAM_BYTES);
  localparam logic [POS_W-1:0] POS_HDR_LAST = POS_W'(stunmap_pkg::HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] POS_HDR = POS_W'(stunmap_pkg::HEADER_BYTES);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0] msg_len_r, msg_len_nxt;
  logic [15:0] kind_r, kind_nxt;
  logic [15:0] val_len_r, val_len_nxt;
  logic [15:0] attr_off_r, attr_off_nxt;
  logic [7:0] family_r, family_nxt;
  logic [15:0] port_r, port_nxt;
  logic [31:0] addr_r, addr_nxt;
  stunmap_pkg::phase_t phase_r, phase_nxt;
  logic [1:0] outcome_r, outcome_nxt;

  logic [7:0] b;
  logic [15:0] o, rel, rel4, new_len;
  logic [17:0] span_end, padded, next_off;
  logic [1:0] status;
  logic found;

  // True when a 4-byte attribute header starting at the given offset fits.
  function automatic logic head_fits(input logic [17:0] off, input logic [15:0] mlen);
    head_fits = (off + 18'd4) <= {2'b00, mlen};
  endfunction

  always_comb begin
    pos_nxt = pos_r;
    msg_len_nxt = msg_len_r;
    kind_nxt = kind_r;
    val_len_nxt = val_len_r;
    attr_off_nxt = attr_off_r;
    family_nxt = family_r;
    port_nxt = port_r;
    addr_nxt = addr_r;
    phase_nxt = phase_r;
    outcome_nxt = outcome_r;
    found = 1'b0;

    b = item.data_byte;
    o = 16'(pos_r) - 16'(stunmap_pkg::HEADER_BYTES);
    rel = o - attr_off_r;
    rel4 = rel - 16'd4;
    new_len = {val_len_r[7:0], b};
    span_end = {2'b00, attr_off_r} + 18'd4 + {2'b00, new_len};
    padded = ({2'b00, val_len_r} + 18'd3) & ~18'd3;
    next_off = {2'b00, attr_off_r} + 18'd4 + padded;

    if (item_go && (pos_r < POS_LIMIT)) begin
      pos_nxt = pos_r + POS_W'(1);
      case (phase_r)
        stunmap_pkg::PH_HEADER: begin
          if (pos_r < POS_W'(2)) begin
            kind_nxt = {kind_r[7:0], b};
          end else if (pos_r < POS_W'(4)) begin
            msg_len_nxt = {msg_len_r[7:0], b};
          end
          if (pos_r == POS_HDR_LAST) begin
            if (kind_r != stunmap_pkg::BINDING_RESPONSE) begin
              outcome_nxt = stunmap_pkg::ST_BAD_TYPE;
              phase_nxt = stunmap_pkg::PH_DONE;
            end else begin
              outcome_nxt = stunmap_pkg::ST_NO_ADDR;
              attr_off_nxt = 16'd0;
              phase_nxt = head_fits(18'd0, msg_len_r) ? stunmap_pkg::PH_ATTR_HEAD
                                                      : stunmap_pkg::PH_DONE;
            end
          end
        end
        stunmap_pkg::PH_ATTR_HEAD: begin
          if (pos_r >= POS_HDR && o >= attr_off_r) begin
            case (rel)
              16'd0: kind_nxt = {8'h00, b};
              16'd1: kind_nxt = {kind_r[7:0], b};
              16'd2: val_len_nxt = {8'h00, b};
              16'd3: begin
                val_len_nxt = new_len;
                if (span_end > {2'b00, msg_len_r}) begin
                  phase_nxt = stunmap_pkg::PH_DONE;
                end else if (new_len == 16'd0) begin
                  if (head_fits({2'b00, attr_off_r} + 18'd4, msg_len_r)) begin
                    attr_off_nxt = attr_off_r + 16'd4;
                  end else begin
                    phase_nxt = stunmap_pkg::PH_DONE;
                  end
                end else begin
                  phase_nxt = stunmap_pkg::PH_ATTR_VALUE;
                end
              end
              default: ;
            endcase
          end
        end
        stunmap_pkg::PH_ATTR_VALUE: begin
          if (pos_r >= POS_HDR && o >= attr_off_r && rel >= 16'd4) begin
            if (kind_r == stunmap_pkg::XOR_MAPPED_ADDRESS &&
                val_len_r >= stunmap_pkg::MIN_ADDR_LEN) begin
              if (rel4 == 16'd1) begin
                family_nxt = b;
              end else if (rel4 == 16'd2 || rel4 == 16'd3) begin
                port_nxt = {port_r[7:0], b};
              end else if (rel4 >= 16'd4 && rel4 <= 16'd7) begin
                addr_nxt = {addr_r[23:0], b};
                if (rel4 == 16'd7 && family_r == stunmap_pkg::FAMILY_IPV4) begin
                  found = 1'b1;
                  outcome_nxt = stunmap_pkg::ST_FOUND;
                  phase_nxt = stunmap_pkg::PH_DONE;
                end
              end
            end
            if (!found && ({2'b00, o} + 18'd1 == next_off)) begin
              if (head_fits(next_off, msg_len_r)) begin
                attr_off_nxt = next_off[15:0];
                phase_nxt = stunmap_pkg::PH_ATTR_HEAD;
              end else begin
                phase_nxt = stunmap_pkg::PH_DONE;
              end
            end
          end
        end
        default: ;
      endcase
    end

    // Result as seen after this byte; only used when it carries the final mark.
    status = (pos_nxt < POS_HDR) ? stunmap_pkg::ST_SHORT : outcome_nxt;
    result.status = status;
    if (status == stunmap_pkg::ST_FOUND) begin
      result.public_address = addr_nxt ^ stunmap_pkg::MAGIC_COOKIE;
      result.mapped_port = port_nxt ^ stunmap_pkg::MAGIC_COOKIE[31:16];
    end else begin
      result.public_address = 32'd0;
      result.mapped_port = 16'd0;
    end

    if (item_go && item.last_byte) begin
      pos_nxt = '0;
      msg_len_nxt = 16'd0;
      kind_nxt = 16'd0;
      val_len_nxt = 16'd0;
      attr_off_nxt = 16'd0;
      family_nxt = 8'd0;
      port_nxt = 16'd0;
      addr_nxt = 32'd0;
      phase_nxt = stunmap_pkg::PH_HEADER;
      outcome_nxt = stunmap_pkg::ST_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      msg_len_r <= 16'd0;
      kind_r <= 16'd0;
      val_len_r <= 16'd0;
      attr_off_r <= 16'd0;
      family_r <= 8'd0;
      port_r <= 16'd0;
      addr_r <= 32'd0;
      phase_r <= stunmap_pkg::PH_HEADER;
      outcome_r <= stunmap_pkg::ST_FOUND;
    end else begin
      pos_r <= pos_nxt;
      msg_len_r <= msg_len_nxt;
      kind_r <= kind_nxt;
      val_len_r <= val_len_nxt;
      attr_off_r <= attr_off_nxt;
      family_r <= family_nxt;
      port_r <= port_nxt;
      addr_r <= addr_nxt;
      phase_r <= phase_nxt;
      outcome_r <= outcome_nxt;
    end
  end

endmodule

FILE: design/stunmap_out_reg.sv
// Result register of the STUN mapped address parser.
// Depends on stunmap_pkg.
module stunmap_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  stunmap_pkg::out_item_t result,
  input  logic                   out_stall,
  output logic                   can_load,
  output logic                   out_valid,
  output stunmap_pkg::out_item_t out_item
);

  logic out_valid_r, out_valid_nxt;
  stunmap_pkg::out_item_t out_item_r;

  always_comb begin
    can_load = !out_valid_r || !out_stall;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item = out_item_r;

endmodule

FILE: design/stunmap_checker.sv
// Port-level checks for the STUN mapped address parser.
// Depends on stunmap_pkg; bound to stun_mapped_address_parser_top.
module stunmap_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input stunmap_pkg::in_item_t  in_item,
  input logic                   out_valid,
  input logic                   out_stall,
  input stunmap_pkg::out_item_t out_item
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Only a waiting, stalled result may hold up the input side.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // Address and port read zero unless a mapped address was found.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != stunmap_pkg::ST_FOUND |->
      out_item.public_address == 32'd0 && out_item.mapped_port == 16'd0)
    else $error("nonzero address fields on a failure result");

  // Reset leaves no result offered.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind stun_mapped_address_parser_top stunmap_checker u_stunmap_checker (.*);
